>>> rtl/lchc_pkg.sv
// ============================================================================
// lchc_pkg
// Shared widths, register indexes and reset values for the LRU cache hit
// counter.
// ============================================================================
`default_nettype none

package lchc_pkg;

    localparam int unsigned KEY_W       = 64;
    localparam int unsigned TOTAL_W     = 64;
    localparam int unsigned CAP_W       = 5;
    localparam int unsigned REWARD_W    = 32;
    localparam int unsigned CFG_DATA_W  = 32;
    localparam int unsigned CFG_INDEX_W = 1;

    localparam int unsigned DEFAULT_WAYS = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_CAPACITY   = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_HIT_REWARD = 1'b1;

    localparam logic [CAP_W-1:0]    CAPACITY_RESET   = 5'd16;
    localparam logic [REWARD_W-1:0] HIT_REWARD_RESET = 32'd1;

endpackage

`default_nettype wire

>>> rtl/lru_cache_hit_counter.sv
// ============================================================================
// lru_cache_hit_counter
// Fully associative cache with rank-based LRU replacement that accumulates a
// saturating reward total over hits.
// ============================================================================
// Pipeline: an input register holds the accepted transaction, then a result
//   register holds the result until the consumer takes it.
// Throughput: one transaction per cycle unless m_tready stalls the output;
//   tag compare, rank update and total add are combinational from way registers.
// Reset: synchronous, active low; clears valid bits, ranks, occupancy, the
//   total and both pipeline valid flags; capacity 16, reward 1. No clearing pass.
`default_nettype none

module lru_cache_hit_counter #(
    parameter int unsigned WAYS = lchc_pkg::DEFAULT_WAYS
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_wr_en,
    input  wire logic [lchc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [lchc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [lchc_pkg::KEY_W-1:0]         s_tdata,   // [63:0] key_tag
    input  wire logic                               s_tuser,   // [0] start_case
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [lchc_pkg::TOTAL_W-1:0]            m_tdata,   // [63:0] total_saved
    output logic                                    m_tuser    // [0] hit
);

    import lchc_pkg::*;

    localparam int unsigned RW   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int unsigned OW   = $clog2(WAYS + 1);
    localparam int unsigned CMW  = (OW > CAP_W) ? OW : CAP_W;
    localparam logic [CMW-1:0] WAYS_CAP = CMW'(WAYS);

    logic [CAP_W-1:0]    capacity_reg;
    logic [REWARD_W-1:0] hit_reward_reg;

    logic              in_valid_reg;
    logic [KEY_W-1:0]  in_key_reg;
    logic              in_start_reg;

    logic [KEY_W-1:0]  tag_reg   [WAYS];
    logic [RW-1:0]     rank_reg  [WAYS];
    logic [WAYS-1:0]   valid_reg;
    logic [OW-1:0]     occ_reg;
    logic [TOTAL_W-1:0] total_reg;

    logic               out_valid_reg;
    logic               out_hit_reg;
    logic [TOTAL_W-1:0] out_total_reg;

    logic               fire;
    logic [WAYS-1:0]    eff_valid;
    logic [OW-1:0]      eff_occ;
    logic [TOTAL_W-1:0] eff_total;
    logic [RW-1:0]      eff_rank  [WAYS];
    logic [WAYS-1:0]    match_vec;
    logic [WAYS-1:0]    hit_oh;
    logic [WAYS-1:0]    free_oh;
    logic [WAYS-1:0]    lru_oh;
    logic [WAYS-1:0]    sel_oh;
    logic               hit;
    logic               insert;
    logic [CMW-1:0]     cap_ext;
    logic [CMW-1:0]     cap_eff;
    logic [OW-1:0]      occ_m1;
    logic [RW-1:0]      last_rank;
    logic [RW-1:0]      hit_rank;
    logic [RW-1:0]      rank_next [WAYS];
    logic [WAYS-1:0]    valid_next;
    logic [OW-1:0]      occ_next;
    logic [TOTAL_W:0]   sum;
    logic [TOTAL_W-1:0] total_next;

    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_total_reg;
    assign m_tuser  = out_hit_reg;

    always_comb begin
        eff_valid = in_start_reg ? '0 : valid_reg;
        eff_occ   = in_start_reg ? '0 : occ_reg;
        eff_total = in_start_reg ? '0 : total_reg;
        for (int i = 0; i < WAYS; i++) begin
            eff_rank[i]  = in_start_reg ? '0 : rank_reg[i];
            match_vec[i] = eff_valid[i] && (tag_reg[i] == in_key_reg);
        end

        hit     = |match_vec;
        hit_oh  = match_vec & (~match_vec + WAYS'(1));
        free_oh = ~eff_valid & (eff_valid + WAYS'(1));

        cap_ext = CMW'(capacity_reg);
        if (cap_ext == '0) begin
            cap_eff = CMW'(1);
        end else if (cap_ext > WAYS_CAP) begin
            cap_eff = WAYS_CAP;
        end else begin
            cap_eff = cap_ext;
        end
        insert = !hit && (CMW'(eff_occ) < cap_eff);

        occ_m1    = eff_occ - OW'(1);
        last_rank = occ_m1[RW-1:0];
        hit_rank  = '0;
        for (int i = 0; i < WAYS; i++) begin
            lru_oh[i] = eff_valid[i] && (eff_rank[i] == last_rank);
            hit_rank  = hit_rank | (eff_rank[i] & {RW{hit_oh[i]}});
        end

        if (hit) begin
            sel_oh = hit_oh;
        end else if (insert) begin
            sel_oh = free_oh;
        end else begin
            sel_oh = lru_oh;
        end

        for (int i = 0; i < WAYS; i++) begin
            if (sel_oh[i]) begin
                rank_next[i] = '0;
            end else if (eff_valid[i] && (!hit || (eff_rank[i] < hit_rank))) begin
                rank_next[i] = eff_rank[i] + RW'(1);
            end else begin
                rank_next[i] = eff_rank[i];
            end
        end

        valid_next = eff_valid | (insert ? free_oh : '0);
        occ_next   = eff_occ + OW'(insert);

        sum = {1'b0, eff_total} + (TOTAL_W + 1)'(hit_reward_reg);
        if (!hit) begin
            total_next = eff_total;
        end else if (sum[TOTAL_W]) begin
            total_next = '1;
        end else begin
            total_next = sum[TOTAL_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg   <= CAPACITY_RESET;
            hit_reward_reg <= HIT_REWARD_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_CAPACITY:   capacity_reg   <= cfg_wdata[CAP_W-1:0];
                REG_HIT_REWARD: hit_reward_reg <= cfg_wdata[REWARD_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_key_reg   <= s_tdata;
            in_start_reg <= s_tuser;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < WAYS; i++) begin
            if (fire && !hit && sel_oh[i]) begin
                tag_reg[i] <= in_key_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            occ_reg   <= '0;
            total_reg <= '0;
            for (int i = 0; i < WAYS; i++) begin
                rank_reg[i] <= '0;
            end
        end else if (fire) begin
            valid_reg <= valid_next;
            occ_reg   <= occ_next;
            total_reg <= total_next;
            for (int i = 0; i < WAYS; i++) begin
                rank_reg[i] <= rank_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_hit_reg   <= hit;
            out_total_reg <= total_next;
        end
    end

    a_occ_matches_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(valid_reg) == 32'(occ_reg))
        else $error("occupancy count differs from number of valid ways");

    a_occ_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        CMW'(occ_reg) <= WAYS_CAP)
        else $error("occupancy above way count");

    a_match_unique: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg |-> $onehot0(match_vec))
        else $error("key present in more than one way");

    a_sel_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |-> $onehot(sel_oh))
        else $error("no single way selected for update");

endmodule

`default_nettype wire
